/* rtl/core/tddfa_pkg.sv */
// Types and constants for the table-driven DFA recognizer.
// No dependencies; imported by the recognizer top level.
`default_nettype none

package tddfa_pkg;

  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 5;
  localparam int ENTRY_W    = 5;
  localparam int VERD_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [OP_W-1:0] {
    OP_SYM_WRITE   = 2'd0,
    OP_TRANS_WRITE = 2'd1,
    OP_SCAN        = 2'd2,
    OP_END         = 2'd3
  } op_t;

  typedef enum logic [VERD_W-1:0] {
    VERD_SCANNING  = 2'd0,
    VERD_ACCEPTED  = 2'd1,
    VERD_REJECTED  = 2'd2,
    VERD_UNDECIDED = 2'd3
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STATES  = 1'd0,
    CFG_NUM_CLASSES = 1'd1
  } cfg_idx_t;

endpackage

`default_nettype wire

/* rtl/core/tddfa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; holds the transition store of the recognizer.
`default_nettype none

module tddfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/table_driven_dfa_recognizer.sv */
// Table-driven DFA recognizer top level: classifier, transition lookup and result register.
// Depends on tddfa_pkg and tddfa_ram.
//
//   channel  handshake            payload
//   in_      in_valid/in_ready    operation, char_byte, class_index, from_state, to_state
//   out_     out_valid/out_ready  present_state, verdict
//   cfg_     cfg_we               cfg_index, cfg_wdata
//
// One request per cycle while in_ready is high; scan and end requests give a result via
// the lookup stage and the result register. Acceptance classifies the character and reads
// the transition RAM; lookup resolves the next state, fed to the next request's address.
// Reset sets the state to 1, clears the verdict and sets the sizes to one state, three classes.
// A stalled result holds the output register; one more request enters the lookup stage.
`default_nettype none

module table_driven_dfa_recognizer #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_CLASSES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tddfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tddfa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tddfa_pkg::OP_W-1:0]          in_operation,
  input  logic [tddfa_pkg::CHAR_W-1:0]        in_char_byte,
  input  logic [tddfa_pkg::IDX_W-1:0]         in_class_index,
  input  logic [tddfa_pkg::IDX_W-1:0]         in_from_state,
  input  logic [tddfa_pkg::IDX_W-1:0]         in_to_state,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tddfa_pkg::IDX_W-1:0]         out_present_state,
  output logic [tddfa_pkg::VERD_W-1:0]        out_verdict
);

  import tddfa_pkg::*;

  localparam int NW    = $clog2(MAX_STATES + 1);
  localparam int SW    = $clog2(MAX_STATES + 3);
  localparam int CW    = $clog2(MAX_CLASSES + 1);
  localparam int SIX   = $clog2(MAX_STATES);
  localparam int CIX   = $clog2(MAX_CLASSES);
  localparam int AW    = CIX + SIX;
  localparam int DEPTH = 1 << AW;
  localparam int CMPW  = (SW > ENTRY_W) ? SW : ENTRY_W;

  // configuration
  logic [NW-1:0]         num_states_r, num_states_nxt;
  logic [CW-1:0]         num_classes_r, num_classes_nxt;
  logic [CFG_DATA_W-1:0] cfg_v;

  always_comb begin
    cfg_v           = cfg_wdata;
    num_states_nxt  = num_states_r;
    num_classes_nxt = num_classes_r;
    if (cfg_we && cfg_idx_t'(cfg_index) == CFG_NUM_STATES) begin
      if (int'(cfg_v) < 1) begin
        num_states_nxt = NW'(1);
      end else if (int'(cfg_v) > MAX_STATES) begin
        num_states_nxt = NW'(MAX_STATES);
      end else begin
        num_states_nxt = NW'(cfg_v);
      end
    end
    if (cfg_we && cfg_idx_t'(cfg_index) == CFG_NUM_CLASSES) begin
      if (int'(cfg_v) < 3) begin
        num_classes_nxt = CW'(3);
      end else if (int'(cfg_v) > MAX_CLASSES) begin
        num_classes_nxt = CW'(MAX_CLASSES);
      end else begin
        num_classes_nxt = CW'(cfg_v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r  <= NW'(1);
      num_classes_r <= CW'(3);
    end else begin
      num_states_r  <= num_states_nxt;
      num_classes_r <= num_classes_nxt;
    end
  end

  logic [SW-1:0] err_st;
  logic [SW-1:0] acc_st;
  assign err_st = SW'(num_states_r) + SW'(1);
  assign acc_st = SW'(num_states_r) + SW'(2);

  // handshake
  logic b_valid_r;
  logic b_adv;
  logic in_fire;
  logic out_valid_r;

  assign b_adv    = !out_valid_r || out_ready;
  assign in_ready = !b_valid_r || b_adv;
  assign in_fire  = in_valid && in_ready;

  op_t a_op;
  assign a_op = op_t'(in_operation);

  // symbol characters
  logic [CHAR_W-1:0] sym_r [MAX_CLASSES];
  logic [CIX-1:0]    sym_waddr;
  logic              sym_we;

  assign sym_waddr = CIX'(in_class_index - IDX_W'(1));
  assign sym_we    = in_fire && a_op == OP_SYM_WRITE &&
                     int'(in_class_index) >= 1 && int'(in_class_index) <= MAX_CLASSES;

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_r[sym_waddr] <= in_char_byte;
    end
  end

  // transition store
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  assign ram_we    = in_fire && a_op == OP_TRANS_WRITE &&
                     int'(in_class_index) >= 1 && int'(in_class_index) <= MAX_CLASSES &&
                     int'(in_from_state) >= 1 && int'(in_from_state) <= MAX_STATES;
  assign ram_waddr = {CIX'(in_class_index - IDX_W'(1)), SIX'(in_from_state - IDX_W'(1))};

  tddfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_to_state),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // architectural state
  logic [SW-1:0] cur_state_r, cur_state_nxt;
  verdict_t      fv_r, fv_nxt;

  // lookup stage
  logic          b_lookup_r;
  logic          b_finish_r;
  logic          b_end_r;
  logic          b_src_ok_r;
  logic [SW-1:0] b_st_r;
  verdict_t      b_fv_r;

  logic [CMPW-1:0] lk_nx;
  logic [SW-1:0]   lk_st;
  logic [SW-1:0]   res_st;
  verdict_t        res_v;

  always_comb begin
    lk_nx = b_src_ok_r ? CMPW'(ram_rdata) : '0;
    if (lk_nx == '0 || lk_nx > CMPW'(acc_st)) begin
      lk_st = err_st;
    end else begin
      lk_st = SW'(lk_nx);
    end
    res_st = b_st_r;
    res_v  = b_fv_r;
    if (b_lookup_r) begin
      res_st = lk_st;
      if (b_finish_r) begin
        if (lk_st == acc_st) begin
          res_v = VERD_ACCEPTED;
        end else if (lk_st == err_st) begin
          res_v = VERD_REJECTED;
        end else begin
          res_v = VERD_UNDECIDED;
        end
      end else begin
        res_v = (lk_st == err_st) ? VERD_REJECTED : VERD_SCANNING;
      end
    end
  end

  // state seen by the request being accepted
  logic [SW-1:0] st_e;
  verdict_t      fv_e;

  always_comb begin
    cur_state_nxt = cur_state_r;
    fv_nxt        = fv_r;
    if (b_valid_r && b_adv) begin
      cur_state_nxt = b_end_r ? SW'(1) : res_st;
      fv_nxt        = b_end_r ? VERD_SCANNING : res_v;
    end
    st_e = b_valid_r ? cur_state_nxt : cur_state_r;
    fv_e = b_valid_r ? fv_nxt : fv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= SW'(1);
      fv_r        <= VERD_SCANNING;
    end else begin
      cur_state_r <= cur_state_nxt;
      fv_r        <= fv_nxt;
    end
  end

  // classify
  logic          is_blank;
  logic          is_digit;
  logic [CW-1:0] cls_k;

  always_comb begin
    is_blank = in_char_byte == CHAR_SPACE ||
               (in_char_byte >= CHAR_TAB && in_char_byte <= CHAR_CR);
    is_digit = in_char_byte >= CHAR_ZERO && in_char_byte <= CHAR_NINE;
    cls_k    = num_classes_r;
    for (int k = MAX_CLASSES - 1; k >= 2; k--) begin
      if (k < int'(num_classes_r) && sym_r[k-1] == in_char_byte) begin
        cls_k = CW'(k);
      end
    end
    if (is_digit) begin
      cls_k = CW'(1);
    end
  end

  // request decode
  logic          a_result;
  logic          a_lookup;
  logic          a_finish;
  logic [SW-1:0] a_st;
  verdict_t      a_fv;
  logic [CW-1:0] a_cls;
  logic          a_src_ok;

  always_comb begin
    a_result = a_op == OP_SCAN || a_op == OP_END;
    a_lookup = 1'b0;
    a_finish = 1'b0;
    a_st     = st_e;
    a_fv     = fv_e;
    a_cls    = (a_op == OP_END) ? num_classes_r - CW'(1) : cls_k;
    a_src_ok = st_e >= SW'(1) && st_e <= SW'(num_states_r);
    case (a_op)
      OP_SCAN: begin
        if (fv_e == VERD_SCANNING && !is_blank) begin
          if (cls_k == num_classes_r) begin
            a_fv = VERD_REJECTED;
          end else if (cls_k == num_classes_r - CW'(1)) begin
            if (st_e == acc_st) begin
              a_fv = VERD_ACCEPTED;
            end else begin
              a_lookup = 1'b1;
              a_finish = 1'b1;
            end
          end else begin
            a_lookup = 1'b1;
          end
        end
      end
      OP_END: begin
        if (fv_e == VERD_SCANNING) begin
          if (st_e == acc_st) begin
            a_fv = VERD_ACCEPTED;
          end else begin
            a_lookup = 1'b1;
            a_finish = 1'b1;
          end
        end
      end
      default: begin
        a_lookup = 1'b0;
      end
    endcase
    ram_re    = in_fire && a_lookup;
    ram_raddr = {CIX'(a_cls - CW'(1)), SIX'(st_e - SW'(1))};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_fire) begin
      b_valid_r <= a_result;
    end else if (b_adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && a_result) begin
      b_lookup_r <= a_lookup;
      b_finish_r <= a_finish;
      b_end_r    <= a_op == OP_END;
      b_src_ok_r <= a_src_ok;
      b_st_r     <= a_st;
      b_fv_r     <= a_fv;
    end
  end

  // result register
  logic [IDX_W-1:0] out_state_r;
  verdict_t         out_verdict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_valid_r) begin
      out_state_r   <= IDX_W'(res_st);
      out_verdict_r <= res_v;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_present_state = out_state_r;
  assign out_verdict       = out_verdict_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !b_valid_r |-> in_ready)
    else $error("input stalled with empty lookup stage");

  a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_state_r != '0)
    else $error("automaton state is zero");

  a_end_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && a_op == OP_END |=> b_valid_r && b_end_r)
    else $error("end request lost before lookup stage");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(b_valid_r))
    else $error("result appeared without a request in lookup stage");

  a_read_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> in_ready && (a_op == OP_SCAN || a_op == OP_END))
    else $error("transition read outside an accepted scan or end request");

endmodule

`default_nettype wire
